>>> hw/rtl/jse_pkg.sv
// shared types, byte codes and slot layout for the json string escaper
`timescale 1ns / 1ps

package jse_pkg;

    // default depth of the queue between front and back
    localparam int JSE_QUEUE_DEPTH = 4;

    // held bytes of an unfinished utf-8 sequence
    localparam int PEND_DEPTH = 3;

    // output slots of one job, emitted in ascending order
    localparam int SLOT_W = 5;
    localparam int SLOT_CNT = 20;
    localparam logic [SLOT_W-1:0] SLOT_OPEN  = 5'd0;
    localparam logic [SLOT_W-1:0] SLOT_PRE   = 5'd1;
    localparam logic [SLOT_W-1:0] SLOT_MAIN  = 5'd4;
    localparam logic [SLOT_W-1:0] SLOT_HI    = 5'd10;
    localparam logic [SLOT_W-1:0] SLOT_POST  = 5'd16;
    localparam logic [SLOT_W-1:0] SLOT_CLOSE = 5'd19;

    // characters
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    // what the main slots of a job carry
    typedef enum logic [1:0] {
        MAIN_RAW,
        MAIN_ESC,
        MAIN_UNI
    } t_main_kind;

    typedef logic [PEND_DEPTH-1:0][7:0] t_pend;

    // one queued job: every output word caused by one input word
    typedef struct packed {
        logic [SLOT_CNT-1:0] mask;
        t_pend               pre_bytes;
        t_pend               post_bytes;
        t_main_kind          kind;
        logic [7:0]          main_byte;
        logic [15:0]         word0;
        logic [15:0]         word1;
    } t_job;

endpackage

>>> hw/rtl/jse_if.sv
// valid/ready channel interfaces for the input and output words
`timescale 1ns / 1ps

interface jse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, data_byte, first_byte, last_byte, input ready);
    modport sink (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface jse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_end;

    modport source (output valid, out_byte, run_end, input ready);
    modport sink (input valid, out_byte, run_end, output ready);
endinterface

>>> hw/rtl/jse_fifo.sv
// small register queue of jobs between front and back
`timescale 1ns / 1ps

module jse_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

>>> hw/rtl/jse_front.sv
// front end: accepts input words, tracks utf-8 decoding, builds jobs
`timescale 1ns / 1ps

module jse_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    jse_in_if.sink        i_in,
    input  logic          i_uni_en,
    input  logic          i_full,
    output logic          o_push,
    output jse_pkg::t_job o_job
);
    import jse_pkg::*;

    t_pend       r_pend;
    logic [1:0]  r_pend_cnt;
    logic [1:0]  r_need_cnt;
    logic [20:0] r_accum;

    t_pend       n_pend;
    logic [1:0]  n_pend_cnt;
    logic [1:0]  n_need_cnt;
    logic [20:0] n_accum;

    logic        accept;
    logic [7:0]  b;
    logic [1:0]  cnt0;
    logic [1:0]  need0;
    logic [20:0] acc0;
    logic [20:0] acc_sh;
    logic [1:0]  need_dec;
    logic [20:0] v;
    logic        do_fresh;
    logic        ok;
    logic        esc_hit;
    logic [7:0]  esc_char;
    logic [1:0]  pre_cnt;
    logic [1:0]  post_cnt;
    logic        main_on;
    logic        pair;
    t_main_kind  kind;
    logic [7:0]  main_byte;
    logic [15:0] word0;
    logic [15:0] word1;
    logic [SLOT_CNT-1:0] mask;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign b          = i_in.data_byte;
    assign o_push     = accept && (mask != '0);

    // two-byte escape lookup
    always_comb begin
        esc_hit  = 1'b1;
        esc_char = b;
        case (b)
            CH_QUOTE:  esc_char = CH_QUOTE;
            CH_BSLASH: esc_char = CH_BSLASH;
            CH_SLASH:  esc_char = CH_SLASH;
            CH_BS:     esc_char = CH_B;
            CH_LF:     esc_char = CH_N;
            CH_FF:     esc_char = CH_F;
            CH_CR:     esc_char = CH_R;
            CH_TAB:    esc_char = CH_T;
            default:   esc_hit  = 1'b0;
        endcase
    end

    // decode step for one input word
    always_comb begin
        cnt0   = i_in.first_byte ? 2'd0 : r_pend_cnt;
        need0  = i_in.first_byte ? 2'd0 : r_need_cnt;
        acc0   = i_in.first_byte ? 21'd0 : r_accum;
        acc_sh = {acc0[14:0], b[5:0]};
        need_dec = need0 - 2'd1;
        v      = acc_sh - 21'h10000;

        n_pend     = r_pend;
        n_pend_cnt = cnt0;
        n_need_cnt = need0;
        n_accum    = acc0;
        do_fresh   = 1'b0;
        ok         = 1'b0;
        pre_cnt    = 2'd0;
        post_cnt   = 2'd0;
        main_on    = 1'b0;
        pair       = 1'b0;
        kind       = MAIN_RAW;
        main_byte  = b;
        word0      = acc_sh[15:0];
        word1      = '0;

        if (cnt0 != 2'd0) begin
            if (b[7:6] != 2'b10) begin
                // broken sequence: held bytes go out raw, byte starts over
                pre_cnt    = cnt0;
                n_pend_cnt = 2'd0;
                n_need_cnt = 2'd0;
                n_accum    = '0;
                do_fresh   = 1'b1;
            end else if (need_dec != 2'd0) begin
                // continuation, more to come
                n_accum    = acc_sh;
                n_need_cnt = need_dec;
                if (cnt0 != 2'd3) begin
                    n_pend[cnt0] = b;
                end
                n_pend_cnt = cnt0 + 2'd1;
            end else begin
                // sequence complete: check range by length
                case (cnt0)
                    2'd1:    ok = (acc_sh >= 21'h80);
                    2'd2:    ok = (acc_sh >= 21'h800) &&
                                  ((acc_sh < 21'hd800) || (acc_sh > 21'hdfff));
                    default: ok = (acc_sh >= 21'h10000) && (acc_sh <= 21'h10ffff);
                endcase
                n_pend_cnt = 2'd0;
                n_need_cnt = 2'd0;
                n_accum    = '0;
                main_on    = 1'b1;
                if (!ok) begin
                    pre_cnt = cnt0;
                    kind    = MAIN_RAW;
                end else begin
                    kind = MAIN_UNI;
                    if (acc_sh > 21'hffff) begin
                        pair  = 1'b1;
                        word0 = {6'b110110, v[19:10]};
                        word1 = {6'b110111, v[9:0]};
                    end
                end
            end
        end else begin
            do_fresh = 1'b1;
        end

        // byte with nothing held
        if (do_fresh) begin
            if (esc_hit) begin
                main_on   = 1'b1;
                kind      = MAIN_ESC;
                main_byte = esc_char;
            end else if (!i_uni_en || !b[7]) begin
                main_on = 1'b1;
            end else if (b >= 8'hc2 && b <= 8'hdf) begin
                n_pend[0]  = b;
                n_pend_cnt = 2'd1;
                n_need_cnt = 2'd1;
                n_accum    = {16'd0, b[4:0]};
            end else if (b >= 8'he0 && b <= 8'hef) begin
                n_pend[0]  = b;
                n_pend_cnt = 2'd1;
                n_need_cnt = 2'd2;
                n_accum    = {17'd0, b[3:0]};
            end else if (b >= 8'hf0 && b <= 8'hf4) begin
                n_pend[0]  = b;
                n_pend_cnt = 2'd1;
                n_need_cnt = 2'd3;
                n_accum    = {18'd0, b[2:0]};
            end else begin
                main_on = 1'b1;
            end
        end

        // last word flushes what is still held
        if (i_in.last_byte) begin
            post_cnt   = n_pend_cnt;
            n_pend_cnt = 2'd0;
            n_need_cnt = 2'd0;
            n_accum    = '0;
        end
    end

    // slot mask of the job
    always_comb begin
        mask = '0;
        mask[SLOT_OPEN] = i_in.first_byte;
        for (int i = 0; i < PEND_DEPTH; i++) begin
            mask[SLOT_PRE + SLOT_W'(i)]  = (pre_cnt > 2'(i));
            mask[SLOT_POST + SLOT_W'(i)] = (post_cnt > 2'(i));
        end
        mask[SLOT_MAIN]      = main_on;
        mask[SLOT_MAIN + 5'd1]  = main_on && (kind != MAIN_RAW);
        mask[SLOT_MAIN + 5'd2 +: 4] = {4{main_on && (kind == MAIN_UNI)}};
        mask[SLOT_HI +: 6]   = {6{main_on && pair}};
        mask[SLOT_CLOSE]     = i_in.last_byte;
    end

    assign o_job.mask       = mask;
    assign o_job.pre_bytes  = r_pend;
    assign o_job.post_bytes = n_pend;
    assign o_job.kind       = kind;
    assign o_job.main_byte  = main_byte;
    assign o_job.word0      = word0;
    assign o_job.word1      = word1;

    // held bytes
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= n_pend;
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt <= '0;
            r_need_cnt <= '0;
            r_accum    <= '0;
        end else if (accept) begin
            r_pend_cnt <= n_pend_cnt;
            r_need_cnt <= n_need_cnt;
            r_accum    <= n_accum;
        end
    end
endmodule

>>> hw/rtl/jse_back.sv
// back end: walks the slots of each job and drives the output register
`timescale 1ns / 1ps

module jse_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  jse_pkg::t_job i_head,
    input  logic          i_empty,
    output logic          o_pop,
    jse_out_if.source     o_out
);
    import jse_pkg::*;

    t_job                r_job;
    logic [SLOT_CNT-1:0] r_mask;
    logic                r_valid;
    logic [7:0]          r_byte;
    logic                r_end;

    t_job                n_job;
    logic [SLOT_CNT-1:0] n_mask;
    logic                n_valid;
    logic [7:0]          n_byte;
    logic                n_end;

    logic [SLOT_CNT-1:0] low;
    logic [SLOT_CNT-1:0] rem;
    logic [SLOT_W-1:0]   idx;
    logic [SLOT_W-1:0]   off;
    logic [7:0]          cur;
    logic                slot_free;

    function automatic logic [7:0] hex_char(input logic [3:0] val);
        return (val < 4'd10) ? (8'h30 + {4'h0, val}) : (8'h57 + {4'h0, val});
    endfunction

    // lowest pending slot
    always_comb begin
        low = r_mask & (~r_mask + 1'b1);
        rem = r_mask & ~low;
        idx = '0;
        for (int i = 0; i < SLOT_CNT; i++) begin
            if (low[i]) begin
                idx = idx | SLOT_W'(i);
            end
        end
    end

    // byte of the selected slot
    always_comb begin
        off = '0;
        cur = CH_QUOTE;
        case (idx)
            SLOT_OPEN, SLOT_CLOSE: cur = CH_QUOTE;
            SLOT_MAIN:        cur = (r_job.kind == MAIN_RAW) ? r_job.main_byte : CH_BSLASH;
            SLOT_MAIN + 5'd1: cur = (r_job.kind == MAIN_ESC) ? r_job.main_byte : CH_U;
            SLOT_HI:          cur = CH_BSLASH;
            SLOT_HI + 5'd1:   cur = CH_U;
            default: begin
                if (idx < SLOT_MAIN) begin
                    off = idx - SLOT_PRE;
                    cur = r_job.pre_bytes[off[1:0]];
                end else if (idx < SLOT_HI) begin
                    off = idx - (SLOT_MAIN + 5'd2);
                    cur = hex_char(r_job.word0[{~off[1:0], 2'b00} +: 4]);
                end else if (idx < SLOT_POST) begin
                    off = idx - (SLOT_HI + 5'd2);
                    cur = hex_char(r_job.word1[{~off[1:0], 2'b00} +: 4]);
                end else begin
                    off = idx - SLOT_POST;
                    cur = r_job.post_bytes[off[1:0]];
                end
            end
        endcase
    end

    // advance one slot per cycle unless the output is stalled, load next job when done
    always_comb begin
        slot_free = !r_valid || o_out.ready;
        n_job     = r_job;
        n_mask    = r_mask;
        n_valid   = r_valid && !o_out.ready;
        n_byte    = r_byte;
        n_end     = r_end;
        o_pop     = 1'b0;
        if (slot_free && (r_mask != '0)) begin
            n_valid = 1'b1;
            n_byte  = cur;
            n_end   = (rem == '0);
            n_mask  = rem;
        end
        if ((n_mask == '0) && !i_empty) begin
            o_pop  = 1'b1;
            n_job  = i_head;
            n_mask = i_head.mask;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_byte <= n_byte;
        r_end  <= n_end;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_mask  <= n_mask;
            r_valid <= n_valid;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.run_end  = r_end;
endmodule

>>> hw/rtl/json_string_escaper.sv
// top level of the json string escaper
`timescale 1ns / 1ps
//
// Streams the bytes of a string, one word per byte on i_in with first_byte
// and last_byte flags, into quoted JSON text on o_out, one byte per word.
// run_end marks the last output word caused by one input word; a word that
// only holds part of a utf-8 sequence, and is not first or last, causes no output.
// i_cfg_we / i_cfg_wdata write the unicode escape enable; write it only while idle.
// The front decodes each input word combinationally and queues a job that
// lists its output slots; the back emits one slot per cycle while o_out is not stalled.
// Path: an accepted input word is written into the job queue, taken from
// its head into the back end's job register, then into the output register.
// Throughput: one output word per cycle while o_out is not stalled, set by the
// back end's single output register; an input word yields as many output
// words as the bytes it produces (1 plain, 2 for an escape, 6 or 12 for \u forms),
// and input is taken every cycle while the QUEUE_DEPTH job queue has room.
// When o_out stalls the output register holds and the queue fills, then
// i_in.ready drops. Reset clears the queue, the decoder state and the
// unicode escape enable; no clearing pass is needed.
//

module json_string_escaper #(
    parameter int QUEUE_DEPTH = jse_pkg::JSE_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    jse_in_if.sink    i_in,
    jse_out_if.source o_out
);
    import jse_pkg::*;

    logic r_uni_en;
    logic push;
    logic pop;
    logic full;
    logic empty;
    t_job job_in;
    t_job job_head;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uni_en <= 1'b0;
        end else if (i_cfg_we) begin
            r_uni_en <= i_cfg_wdata;
        end
    end

    jse_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_uni_en (r_uni_en),
        .i_full   (full),
        .o_push   (push),
        .o_job    (job_in)
    );

    jse_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_rdata (job_head),
        .o_empty (empty)
    );

    jse_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (job_head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );
endmodule

>>> hw/rtl/jse_checker.sv
// port-level checks on the escaper output, bound to the top level
`timescale 1ns / 1ps

module jse_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_run_end
);
    // output word stays offered until taken
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    // stalled word keeps its payload
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_byte) && $stable(i_run_end))
        else $error("output word changed while stalled");

    // offered word carries known bits
    a_payload_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !$isunknown({i_out_byte, i_run_end}))
        else $error("output word has unknown bits");

    // no word offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");
endmodule

bind json_string_escaper jse_checker u_jse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_run_end   (o_out.run_end)
);
